// ----- rtl/sidr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sidr_pkg;

   localparam logic [15:0] SYNC_FIRST  = 16'h5487;
   localparam logic [15:0] SYNC_SECOND = 16'hffff;
   localparam logic [7:0]  REPLY_LO    = 8'h54;
   localparam logic [7:0]  REPLY_HI    = 8'h87;
   localparam logic [31:0] BASE_RESET  = 32'h0008_0000;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_TX   = 2'd0,
      KIND_MEM  = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_HUNT1 = 3'd0,
      PH_HUNT2 = 3'd1,
      PH_SIZE  = 3'd2,
      PH_DATA  = 3'd3,
      PH_ACK   = 3'd4,
      PH_DONE  = 3'd5
   } phase_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  data_byte;
      logic [31:0] mem_addr;
      logic        last;
   } rsp_item_type;

endpackage
`default_nettype wire

// ----- rtl/sidr_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface sidr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/sidr_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface sidr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  data_byte;
   logic [31:0] mem_addr;
   logic        last;

   modport source (output valid, output result_kind, output data_byte,
                   output mem_addr, output last, input ready);
   modport sink (input valid, input result_kind, input data_byte,
                 input mem_addr, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/sidr_csr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface sidr_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] load_base;

   modport source (output valid, output load_base, input ready);
   modport sink (input valid, input load_base, output ready);
endinterface
`default_nettype wire

// ----- rtl/serial_image_download_receiver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Serial image download receiver. Each req beat carries one byte from the serial line; the
// block hunts the sync word 0x5487 (answering with transmit beats 0x54, 0x87), then 0xFFFF,
// reads a little-endian 32-bit size and turns each image byte into a memory write at
// load_base plus its index, then transmits the XOR checksum and waits for an acknowledge
// byte (zero completes, nonzero restarts at the size). A byte is processed in the cycle it
// is accepted and its results enter a four-entry result queue, so a byte can be taken every
// cycle while the queue holds fewer than three beats. The rsp side drains one beat per cycle
// from that queue while rsp.ready is high; the sync byte and the last image byte produce two
// beats, every other byte at most one. The csr port is always ready.
module serial_image_download_receiver (
   input  wire logic  clock,
   input  wire logic  reset,
   sidr_req_if.sink   req,
   sidr_rsp_if.source rsp,
   sidr_csr_if.sink   csr
);
   import sidr_pkg::*;

   logic [31:0]  load_base_ff;
   phase_type    phase_ff, phase_in;
   logic [15:0]  sync_shift_ff, sync_shift_in;
   logic [1:0]   size_seen_ff, size_seen_in;
   logic [31:0]  image_size_ff, image_size_in;
   logic [31:0]  bytes_rcvd_ff, bytes_rcvd_in;
   logic [7:0]   running_xor_ff, running_xor_in;

   rsp_item_type queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   logic         accept;
   logic         pop;
   logic [1:0]   push_n;
   rsp_item_type res0, res1;

   logic [7:0]   b;
   logic [15:0]  shift_next;
   logic [31:0]  size_or;
   logic [31:0]  rcvd_inc;
   logic [7:0]   xor_next;

   assign csr.ready = 1'b1;
   assign req.ready = (count_ff < QCNT_W'(QUEUE_DEPTH - 1));
   assign accept    = req.valid && req.ready;
   assign pop       = rsp.valid && rsp.ready;

   assign b          = req.rx_byte;
   assign shift_next = {sync_shift_ff[7:0], b};
   assign size_or    = image_size_ff | ({24'd0, b} << {size_seen_ff, 3'b000});
   assign rcvd_inc   = bytes_rcvd_ff + 32'd1;
   assign xor_next   = running_xor_ff ^ b;

   // Next phase and the download counters.
   always_comb begin
      phase_in       = phase_ff;
      sync_shift_in  = sync_shift_ff;
      size_seen_in   = size_seen_ff;
      image_size_in  = image_size_ff;
      bytes_rcvd_in  = bytes_rcvd_ff;
      running_xor_in = running_xor_ff;
      case (phase_ff)
         PH_HUNT1: begin
            if (shift_next == SYNC_FIRST) begin
               sync_shift_in = 16'd0;
               phase_in      = PH_HUNT2;
            end else begin
               sync_shift_in = shift_next;
            end
         end
         PH_HUNT2: begin
            sync_shift_in = shift_next;
            if (shift_next == SYNC_SECOND) begin
               phase_in       = PH_SIZE;
               size_seen_in   = 2'd0;
               image_size_in  = 32'd0;
               bytes_rcvd_in  = 32'd0;
               running_xor_in = 8'd0;
            end
         end
         PH_SIZE: begin
            image_size_in = size_or;
            size_seen_in  = size_seen_ff + 2'd1;
            if (size_seen_ff == 2'd3) begin
               bytes_rcvd_in  = 32'd0;
               running_xor_in = 8'd0;
               phase_in       = (size_or == 32'd0) ? PH_ACK : PH_DATA;
            end
         end
         PH_DATA: begin
            running_xor_in = xor_next;
            bytes_rcvd_in  = rcvd_inc;
            if (rcvd_inc == image_size_ff) begin
               phase_in = PH_ACK;
            end
         end
         PH_ACK: begin
            if (b == 8'd0) begin
               phase_in = PH_DONE;
            end else begin
               phase_in       = PH_SIZE;
               size_seen_in   = 2'd0;
               image_size_in  = 32'd0;
               bytes_rcvd_in  = 32'd0;
               running_xor_in = 8'd0;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // Result beats caused by the current byte.
   always_comb begin
      push_n = 2'd0;
      res0   = '{result_kind: KIND_TX, data_byte: 8'd0, mem_addr: 32'd0, last: 1'b1};
      res1   = '{result_kind: KIND_TX, data_byte: 8'd0, mem_addr: 32'd0, last: 1'b1};
      case (phase_ff)
         PH_HUNT1: begin
            if (shift_next == SYNC_FIRST) begin
               push_n         = 2'd2;
               res0.data_byte = REPLY_LO;
               res0.last      = 1'b0;
               res1.data_byte = REPLY_HI;
            end
         end
         PH_SIZE: begin
            if (size_seen_ff == 2'd3 && size_or == 32'd0) begin
               push_n = 2'd1;
            end
         end
         PH_DATA: begin
            res0.result_kind = KIND_MEM;
            res0.data_byte   = b;
            res0.mem_addr    = load_base_ff + bytes_rcvd_ff;
            res1.data_byte   = xor_next;
            if (rcvd_inc == image_size_ff) begin
               push_n    = 2'd2;
               res0.last = 1'b0;
            end else begin
               push_n = 2'd1;
            end
         end
         PH_ACK: begin
            if (b == 8'd0) begin
               push_n           = 2'd1;
               res0.result_kind = KIND_DONE;
            end
         end
         default: begin
            push_n = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_base_ff   <= BASE_RESET;
         phase_ff       <= PH_HUNT1;
         sync_shift_ff  <= 16'd0;
         size_seen_ff   <= 2'd0;
         image_size_ff  <= 32'd0;
         bytes_rcvd_ff  <= 32'd0;
         running_xor_ff <= 8'd0;
      end else begin
         if (csr.valid) begin
            load_base_ff <= csr.load_base;
         end
         if (accept) begin
            phase_ff       <= phase_in;
            sync_shift_ff  <= sync_shift_in;
            size_seen_ff   <= size_seen_in;
            image_size_ff  <= image_size_in;
            bytes_rcvd_ff  <= bytes_rcvd_in;
            running_xor_ff <= running_xor_in;
         end
      end
   end

   // Result queue. Both beats of a byte are written in the same cycle.
   logic [1:0]        push_eff;
   logic [QCNT_W-1:0] count_in;

   assign push_eff = accept ? push_n : 2'd0;
   assign count_in = count_ff + QCNT_W'(push_eff) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QPTR_W'(push_eff);
         rd_ptr_ff <= rd_ptr_ff + QPTR_W'(pop);
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_eff != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_eff == 2'd2) begin
         queue_ff[wr_ptr_ff + QPTR_W'(1)] <= res1;
      end
   end

   assign rsp.valid       = (count_ff != '0);
   assign rsp.result_kind = queue_ff[rd_ptr_ff].result_kind;
   assign rsp.data_byte   = queue_ff[rd_ptr_ff].data_byte;
   assign rsp.mem_addr    = queue_ff[rd_ptr_ff].mem_addr;
   assign rsp.last        = queue_ff[rd_ptr_ff].last;

   // A beat that is not the last of its byte always has its partner queued behind it.
   a_pair_complete: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.last) |-> (count_ff >= QCNT_W'(2)))
      else $error("first beat of a pair without its partner in the queue");

   // Once the load is complete, no byte produces a result.
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_DONE) |=> (count_ff <= $past(count_ff)))
      else $error("result produced after load completion");

   // The queue never holds more beats than it has entries.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import sidr_pkg::*;

   typedef struct {
      logic [7:0]   rx;
      int           n_fixed;   // -1: results come from the decoder model below
      rsp_item_type fixed0;
      rsp_item_type fixed1;
   } byte_plan_type;

   logic clock;
   logic reset = 1'b1;

   sidr_req_if req_bus ();
   sidr_rsp_if rsp_bus ();
   sidr_csr_if csr_bus ();

   serial_image_download_receiver uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // Model of the download state, updated on every accepted byte.
   phase_type   dl_phase   = PH_HUNT1;
   logic [15:0] sync_word  = '0;
   logic [1:0]  size_idx   = '0;
   logic [31:0] img_size   = '0;
   logic [31:0] byte_count = '0;
   logic [7:0]  xsum       = '0;
   logic [31:0] base_addr  = BASE_RESET;

   rsp_item_type  pending_beats [$];
   byte_plan_type offered_bytes [$];
   byte_plan_type directed_rows [$];
   int            mismatches    = 0;
   int            bytes_sent    = 0;
   int            base_writes   = 0;
   bit            send_fast     = 1'b0;
   bit            rsp_hold_req  = 1'b0;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic rsp_item_type make_beat(kind_type k, logic [7:0] d, logic [31:0] a,
                                              logic l);
      rsp_item_type r;
      r.result_kind = k;
      r.data_byte   = d;
      r.mem_addr    = a;
      r.last        = l;
      return r;
   endfunction

   function automatic byte_plan_type plain(logic [7:0] b);
      byte_plan_type p;
      p.rx      = b;
      p.n_fixed = -1;
      p.fixed0  = '0;
      p.fixed1  = '0;
      return p;
   endfunction

   function automatic logic [31:0] next_base();
      case (base_writes)
         0: return 32'hFFFF_FFFF;
         1: return 32'h0000_0000;
         2: return 32'hFFFF_FFF8;
         default: begin
            case ($urandom_range(0, 3))
               0: return BASE_RESET;
               1: return 32'hFFFF_FFFF;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   task automatic restart_download();
      dl_phase   = PH_SIZE;
      size_idx   = '0;
      img_size   = '0;
      byte_count = '0;
      xsum       = '0;
   endtask

   task automatic decode_rx_byte(input logic [7:0] b, input bit record);
      rsp_item_type res [$];
      logic [31:0]  addr;
      case (dl_phase)
         PH_HUNT1: begin
            sync_word = {sync_word[7:0], b};
            if (sync_word == SYNC_FIRST) begin
               res.push_back(make_beat(KIND_TX, REPLY_LO, '0, 1'b0));
               res.push_back(make_beat(KIND_TX, REPLY_HI, '0, 1'b1));
               sync_word = '0;
               dl_phase  = PH_HUNT2;
            end
         end
         PH_HUNT2: begin
            sync_word = {sync_word[7:0], b};
            if (sync_word == SYNC_SECOND) restart_download();
         end
         PH_SIZE: begin
            img_size = img_size | ({24'd0, b} << (8 * size_idx));
            size_idx = size_idx + 2'd1;
            if (size_idx == 2'd0) begin
               byte_count = '0;
               xsum       = '0;
               if (img_size == 32'd0) begin
                  res.push_back(make_beat(KIND_TX, 8'h00, '0, 1'b1));
                  dl_phase = PH_ACK;
               end else begin
                  dl_phase = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            addr       = base_addr + byte_count;
            xsum       = xsum ^ b;
            byte_count = byte_count + 32'd1;
            if (byte_count == img_size) begin
               res.push_back(make_beat(KIND_MEM, b, addr, 1'b0));
               res.push_back(make_beat(KIND_TX, xsum, '0, 1'b1));
               dl_phase = PH_ACK;
            end else begin
               res.push_back(make_beat(KIND_MEM, b, addr, 1'b1));
            end
         end
         PH_ACK: begin
            if (b == 8'h00) begin
               res.push_back(make_beat(KIND_DONE, 8'h00, '0, 1'b1));
               dl_phase = PH_DONE;
            end else begin
               restart_download();
            end
         end
         default: ;
      endcase
      if (record) foreach (res[i]) pending_beats.push_back(res[i]);
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin : monitor
      byte_plan_type p;
      rsp_item_type  want;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) base_addr = csr_bus.load_base;
         if (req_bus.valid && req_bus.ready) begin
            p = offered_bytes.pop_front();
            decode_rx_byte(req_bus.rx_byte, p.n_fixed < 0);
            if (p.n_fixed >= 1) pending_beats.push_back(p.fixed0);
            if (p.n_fixed >= 2) pending_beats.push_back(p.fixed1);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_beats.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual %h %h %h %b",
                        $time, rsp_bus.result_kind, rsp_bus.data_byte,
                        rsp_bus.mem_addr, rsp_bus.last);
               mismatches++;
            end else begin
               want = pending_beats.pop_front();
               if (rsp_bus.result_kind !== want.result_kind)
                  report_mismatch("result_kind", 32'(want.result_kind),
                                  32'(rsp_bus.result_kind));
               if (rsp_bus.data_byte !== want.data_byte)
                  report_mismatch("data_byte", 32'(want.data_byte), 32'(rsp_bus.data_byte));
               if (rsp_bus.mem_addr !== want.mem_addr)
                  report_mismatch("mem_addr", want.mem_addr, rsp_bus.mem_addr);
               if (rsp_bus.last !== want.last)
                  report_mismatch("last", 32'(want.last), 32'(rsp_bus.last));
            end
         end
      end
   end

   // Result side: random back-pressure, occasional runs at full rate, and one long hold-off
   // on request from the sender so that the block's result queue fills up.
   initial begin : rsp_drain
      int w;
      bit fast;
      fast = 1'b0;
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (120) @(posedge clock);
            rsp_hold_req = 1'b0;
         end
         if ($urandom_range(0, 31) == 0) fast = !fast;
         w = fast ? 0 : $urandom_range(0, 3);
         if (w != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   task automatic send_byte(input byte_plan_type p);
      int w;
      w = send_fast ? 0 : $urandom_range(0, 3);
      if (w != 0) begin
         req_bus.valid <= 1'b0;
         repeat (w) @(posedge clock);
      end
      offered_bytes.push_back(p);
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= p.rx;
      bytes_sent++;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // The sender stops here until every expected beat has come back, then lets the block
   // settle before the base address changes.
   task automatic write_load_base(input logic [31:0] v);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.load_base <= v;
      base_writes++;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic add_row(input logic [7:0] b, input int n,
                          input rsp_item_type f0 = '0, input rsp_item_type f1 = '0);
      byte_plan_type p;
      p.rx      = b;
      p.n_fixed = n;
      p.fixed0  = f0;
      p.fixed1  = f1;
      directed_rows.push_back(p);
   endtask

   initial begin : stimulus
      logic [31:0] sz;
      int          dl;
      int          n_large;
      int          r;
      bit          mid_write;

      req_bus.valid     <= 1'b0;
      req_bus.rx_byte   <= 8'h00;
      csr_bus.valid     <= 1'b0;
      csr_bus.load_base <= 32'h0;

      // Noise and a false start, then the sync word split across an overlapping 0x54.
      add_row(8'h87, 0);
      add_row(8'h54, 0);
      add_row(8'hFF, 0);
      add_row(8'h54, 0);
      add_row(8'h54, 0);
      add_row(8'h87, 2, make_beat(KIND_TX, REPLY_LO, '0, 1'b0),
                        make_beat(KIND_TX, REPLY_HI, '0, 1'b1));
      // The second sync word must be found in a cleared shift register.
      add_row(8'hFF, 0);
      add_row(8'h7F, 0);
      add_row(8'hFF, 0);
      add_row(8'hFF, 0);
      // A zero-length image sends its checksum right after the fourth size byte.
      add_row(8'h00, 0);
      add_row(8'h00, 0);
      add_row(8'h00, 0);
      add_row(8'h00, 1, make_beat(KIND_TX, 8'h00, '0, 1'b1));
      add_row(8'h80, 0);
      // Three-byte image at the reset base address, then a restart.
      add_row(8'h03, 0);
      add_row(8'h00, 0);
      add_row(8'h00, 0);
      add_row(8'h00, 0);
      add_row(8'hFF, 1, make_beat(KIND_MEM, 8'hFF, BASE_RESET, 1'b1));
      add_row(8'h00, -1);
      add_row(8'hA5, -1);
      add_row(8'h01, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_byte(directed_rows[i]);

      // Random downloads, each restarted by a nonzero acknowledgement; the last one is
      // acknowledged with zero.
      dl      = 0;
      n_large = 0;
      while (bytes_sent < 800) begin
         if (dl % 4 == 3) write_load_base(next_base());
         send_fast = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (dl == 1) begin
            sz           = 32'd40;
            send_fast    = 1'b1;
            rsp_hold_req = 1'b1;
         end else if (r < 8) begin
            sz = 32'd0;
         end else if (r < 12 && n_large < 3) begin
            sz = $urandom_range(150, 260);
            n_large++;
         end else begin
            sz = $urandom_range(1, 12);
         end
         for (int k = 0; k < 4; k++) send_byte(plain(sz[8*k +: 8]));
         mid_write = (sz >= 4) && ($urandom_range(0, 9) == 0);
         for (int i = 0; i < sz; i++) begin
            if (mid_write && i == sz / 2) write_load_base(next_base());
            send_byte(plain($urandom_range(0, 255)));
         end
         // The acknowledgement that ends the loop is always the zero one.
         if (bytes_sent >= 799) send_byte(plain(8'h00));
         else send_byte(plain($urandom_range(1, 255)));
         dl++;
      end

      // After completion every byte is ignored.
      repeat (12) send_byte(plain($urandom_range(0, 255)));
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/sidr_pkg.sv
rtl/sidr_req_if.sv
rtl/sidr_rsp_if.sv
rtl/sidr_csr_if.sv
rtl/serial_image_download_receiver.sv
tb/tb.sv
